// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the DFA matcher RTL.
// Concurrent checks are compiled in simulation and drop out in synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, disabled while reset is high.
`define DFA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked check that also holds during reset.
`define DFA_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define DFA_ASSERT(name, clk, rst, prop)

`define DFA_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: rtl/dfa_pkg.sv
// ---------------------------------------------------------------------------
// dfa_pkg
// Sizes, operation and status codes, and inter-module structs of the matcher.
// ---------------------------------------------------------------------------
`default_nettype none

package dfa_pkg;

  localparam int NUM_STATES  = 64;
  localparam int NUM_SYMBOLS = 256;

  // Fixed payload field widths.
  localparam int OP_W     = 2;
  localparam int KIND_W   = 2;
  localparam int STFLD_W  = 6;
  localparam int SYMFLD_W = 8;
  localparam int STAT_W   = 4;

  // Internal widths.
  localparam int SID_W     = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
  localparam int SYM_W     = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int TBL_AW    = SID_W + SYM_W;
  localparam int TBL_DEPTH = 1 << TBL_AW;
  localparam int ENTRY_W   = SID_W + 1;   // valid bit on top of target id

  typedef enum logic [OP_W-1:0] {
    OP_ADD_STATE = 2'd0,
    OP_ADD_TRANS = 2'd1,
    OP_FINISH    = 2'd2,
    OP_FEED      = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 4'd0,
    ST_START_SET = 4'd1,
    ST_FULL      = 4'd2,
    ST_TRANS_SET = 4'd3,
    ST_NO_START  = 4'd4,
    ST_NO_ACCEPT = 4'd5,
    ST_NOT_READY = 4'd6,
    ST_ACCEPTED  = 4'd7,
    ST_REJECTED  = 4'd8,
    ST_CONTINUE  = 4'd9
  } status_t;

  // Transition table port request.
  typedef struct packed {
    logic               we;
    logic [TBL_AW-1:0]  waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [TBL_AW-1:0]  raddr;
  } tbl_req_t;

  // Result handed from the control to the output register.
  typedef struct packed {
    logic                valid;
    status_t             status;
    logic [STFLD_W-1:0]  id;
  } rsp_push_t;

endpackage

`default_nettype wire

// File: rtl/dfa_if.sv
// ---------------------------------------------------------------------------
// dfa_cmd_if / dfa_rsp_if
// Valid/ready channels for commands into and results out of the matcher.
// ---------------------------------------------------------------------------
`default_nettype none

interface dfa_cmd_if
  import dfa_pkg::*;
  ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     operation;
  logic [KIND_W-1:0]   state_kind;
  logic [STFLD_W-1:0]  from_state;
  logic [STFLD_W-1:0]  to_state;
  logic [SYMFLD_W-1:0] symbol;
  logic                greedy;

  modport source (
    output valid, operation, state_kind, from_state, to_state, symbol, greedy,
    input  ready
  );
  modport sink (
    input  valid, operation, state_kind, from_state, to_state, symbol, greedy,
    output ready
  );
endinterface

interface dfa_rsp_if
  import dfa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [STFLD_W-1:0] new_state_id;

  modport source (output valid, status, new_state_id, input ready);
  modport sink   (input valid, status, new_state_id, output ready);
endinterface

`default_nettype wire

// File: rtl/dfa_ram.sv
// ---------------------------------------------------------------------------
// dfa_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module dfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Hold read data when no read is issued.
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/dfa_rsp_buf.sv
// ---------------------------------------------------------------------------
// dfa_rsp_buf
// One-entry output register between the control and the result channel.
// ---------------------------------------------------------------------------
`default_nettype none

module dfa_rsp_buf
  import dfa_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  rsp_push_t        push,
  output logic             push_ready,
  dfa_rsp_if.source        rsp
);

  logic               full;
  logic [STAT_W-1:0]  status;
  logic [STFLD_W-1:0] id;

  // Free when empty or draining this cycle.
  assign push_ready = !full || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push.valid && push_ready) begin
      full <= 1'b1;
    end else if (rsp.ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid && push_ready) begin
      status <= push.status;
      id     <= push.id;
    end
  end

  assign rsp.valid        = full;
  assign rsp.status       = status;
  assign rsp.new_state_id = id;

endmodule

`default_nettype wire

// File: rtl/dfa_ctrl.sv
// ---------------------------------------------------------------------------
// dfa_ctrl
// Command sequencer: clears the transition table, builds and steps the DFA.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module dfa_ctrl
  import dfa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  dfa_cmd_if.sink            cmd,
  output tbl_req_t           tbl,
  input  logic [ENTRY_W-1:0] tbl_rdata,
  output rsp_push_t          push,
  input  logic               push_ready
);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_EXEC  = 3'b100
  } state_t;

  state_t state, state_next;

  logic [TBL_AW-1:0] clr_addr;

  // Latched command.
  op_t                 op_q;
  logic [KIND_W-1:0]   kind_q;
  logic [STFLD_W-1:0]  from_q;
  logic [STFLD_W-1:0]  to_q;
  logic [SYMFLD_W-1:0] sym_q;
  logic                greedy_q;

  // Machine state.
  logic [NUM_STATES-1:0] accept_marks, accept_marks_next;
  logic [SID_W-1:0]      current_state, current_state_next;
  logic [SID_W-1:0]      start_state, start_state_next;
  logic                  start_valid, start_valid_next;
  logic [SID_W:0]        next_free_id, next_free_id_next;
  logic                  any_accept, any_accept_next;
  logic                  armed, armed_next;

  logic               accept_fire;
  logic               exec_fire;
  logic               from_ok, to_ok, sym_ok;
  logic               entry_valid;
  logic [SID_W-1:0]   entry_id;
  logic [SID_W-1:0]   new_id;
  logic               trans_we;
  status_t            status;
  logic [STFLD_W-1:0] id_out;

  assign cmd.ready   = (state == S_IDLE);
  assign accept_fire = cmd.valid && cmd.ready;
  assign exec_fire   = (state == S_EXEC) && push_ready;

  assign from_ok     = int'(from_q) < NUM_STATES;
  assign to_ok       = int'(to_q) < NUM_STATES;
  assign sym_ok      = int'(sym_q) < NUM_SYMBOLS;
  assign entry_valid = tbl_rdata[ENTRY_W-1];
  assign entry_id    = tbl_rdata[SID_W-1:0];
  assign new_id      = next_free_id[SID_W-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (clr_addr == {TBL_AW{1'b1}}) state_next = S_IDLE;
      S_IDLE:  if (accept_fire) state_next = S_EXEC;
      S_EXEC:  if (push_ready) state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  // Execute stage: resolve the latched command against the table read data.
  always_comb begin
    accept_marks_next  = accept_marks;
    current_state_next = current_state;
    start_state_next   = start_state;
    start_valid_next   = start_valid;
    next_free_id_next  = next_free_id;
    any_accept_next    = any_accept;
    armed_next         = armed;
    trans_we           = 1'b0;
    status             = ST_OK;
    id_out             = '0;
    unique case (op_q)
      OP_ADD_STATE: begin
        if (next_free_id >= (SID_W+1)'(NUM_STATES)) begin
          status = ST_FULL;
        end else begin
          next_free_id_next = next_free_id + (SID_W+1)'(1);
          if (kind_q[0] && start_valid) begin
            status = ST_START_SET;
          end else begin
            if (kind_q[0]) begin
              start_valid_next   = 1'b1;
              start_state_next   = new_id;
              current_state_next = new_id;
            end
            if (kind_q[1]) begin
              accept_marks_next[new_id] = 1'b1;
              any_accept_next           = 1'b1;
            end
            id_out = STFLD_W'(new_id);
          end
        end
      end
      OP_ADD_TRANS: begin
        if (!(from_ok && to_ok && sym_ok)) begin
          status = ST_FULL;
        end else if (entry_valid) begin
          status = ST_TRANS_SET;
        end else begin
          trans_we = 1'b1;
        end
      end
      OP_FINISH: begin
        if (!start_valid) begin
          status = ST_NO_START;
        end else if (!any_accept) begin
          status = ST_NO_ACCEPT;
        end else begin
          armed_next = 1'b1;
        end
      end
      OP_FEED: begin
        if (!armed) begin
          status = ST_NOT_READY;
        end else if (!sym_ok || !entry_valid) begin
          current_state_next = start_state;
          status             = ST_REJECTED;
        end else if (accept_marks[entry_id]) begin
          current_state_next = greedy_q ? entry_id : start_state;
          status             = ST_ACCEPTED;
        end else begin
          current_state_next = entry_id;
          status             = ST_CONTINUE;
        end
      end
      default: status = ST_OK;
    endcase
  end

  // Table port: clear sweep, read on accept, write on a committed add.
  always_comb begin
    tbl = '0;
    if (state == S_CLEAR) begin
      tbl.we    = 1'b1;
      tbl.waddr = clr_addr;
    end else if (exec_fire && trans_we) begin
      tbl.we    = 1'b1;
      tbl.waddr = {SID_W'(from_q), SYM_W'(sym_q)};
      tbl.wdata = {1'b1, SID_W'(to_q)};
    end
    tbl.re = accept_fire;
    if (op_t'(cmd.operation) == OP_FEED) begin
      tbl.raddr = {current_state, SYM_W'(cmd.symbol)};
    end else begin
      tbl.raddr = {SID_W'(cmd.from_state), SYM_W'(cmd.symbol)};
    end
  end

  assign push.valid  = (state == S_EXEC);
  assign push.status = status;
  assign push.id     = id_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_addr      <= '0;
      accept_marks  <= '0;
      current_state <= '0;
      start_state   <= '0;
      start_valid   <= 1'b0;
      next_free_id  <= '0;
      any_accept    <= 1'b0;
      armed         <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + TBL_AW'(1);
      end
      // Commit only when the result is taken by the output register.
      if (exec_fire) begin
        accept_marks  <= accept_marks_next;
        current_state <= current_state_next;
        start_state   <= start_state_next;
        start_valid   <= start_valid_next;
        next_free_id  <= next_free_id_next;
        any_accept    <= any_accept_next;
        armed         <= armed_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept_fire) begin
      op_q     <= op_t'(cmd.operation);
      kind_q   <= cmd.state_kind;
      from_q   <= cmd.from_state;
      to_q     <= cmd.to_state;
      sym_q    <= cmd.symbol;
      greedy_q <= cmd.greedy;
    end
  end

  `DFA_ASSERT(a_accept_then_exec, clk, rst, accept_fire |=> (state == S_EXEC))
  `DFA_ASSERT(a_exec_then_idle, clk, rst, exec_fire |=> (state == S_IDLE))
  `DFA_ASSERT(a_write_only_trans, clk, rst, (tbl.we && state != S_CLEAR) |-> (op_q == OP_ADD_TRANS))
  `DFA_ASSERT(a_armed_has_start, clk, rst, armed |-> (start_valid && any_accept))
  `DFA_ASSERT(a_no_rw_overlap, clk, rst, !(tbl.we && tbl.re))

endmodule

`default_nettype wire

// File: rtl/table_driven_dfa_matcher.sv
// ---------------------------------------------------------------------------
// table_driven_dfa_matcher
// Table-driven DFA engine, built and stepped through one command channel.
// ---------------------------------------------------------------------------
//
//   channel  direction  payload
//   -------  ---------  ---------------------------------------------------
//   cmd      in         operation, state_kind, from_state, to_state,
//                       symbol, greedy
//   rsp      out        status, new_state_id
//
// Every command passes through an accept cycle and the execute state: the
// accept cycle issues the transition table read, the execute state uses the
// registered read data and produces the result. One command is in flight.
// After reset all 16384 table entries are swept to invalid, one entry per
// cycle; cmd.ready stays low until the sweep is done.
// A stalled rsp holds the execute stage; state commits only when the result
// transaction enters the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module table_driven_dfa_matcher
  import dfa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  dfa_cmd_if.sink    cmd,
  dfa_rsp_if.source  rsp
);

  tbl_req_t           tbl;
  logic [ENTRY_W-1:0] tbl_rdata;
  rsp_push_t          push;
  logic               push_ready;

  // Sequencer: clear sweep, command decode, DFA registers and accept marks.
  dfa_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .tbl        (tbl),
    .tbl_rdata  (tbl_rdata),
    .push       (push),
    .push_ready (push_ready)
  );

  // Transition table: entry = {valid, target id}, addressed by {state, symbol}.
  dfa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (tbl.we),
    .waddr (tbl.waddr),
    .wdata (tbl.wdata),
    .re    (tbl.re),
    .raddr (tbl.raddr),
    .rdata (tbl_rdata)
  );

  // Output register: holds one result so the sequencer can go on while it waits.
  dfa_rsp_buf u_rsp_buf (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .rsp        (rsp)
  );

endmodule

`default_nettype wire
